// ----- rtl/gclru_pkg.sv -----
// ----------------------------------------------------------------------------
// gclru_pkg
// Shared types and constants for the glyph cache tag store with LRU allocation.
// ----------------------------------------------------------------------------
package gclru_pkg;

  localparam int ENTRIES_DEF     = 512;
  localparam int STAMP_WIDTH_DEF = 32;
  localparam int SLOT_W          = 9;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic        [15:0] glyph_index;
    logic        [9:0]  pixel_size;
    logic        [7:0]  style_bits;
    logic signed [31:0] angle;
  } req_t;

  localparam int KEY_W = $bits(req_t);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } rsp_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t key;
  } req_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ----- rtl/glyph_cache_lru_allocator_top.sv -----
// ----------------------------------------------------------------------------
// glyph_cache_lru_allocator_top
// Fully associative glyph tag store with least-recently-used allocation. A
// lookup transaction carries a key (glyph index, pixel size, style bits,
// angle); a hit refreshes that entry's stamp and returns its slot, a miss
// takes the lowest free slot or else the lowest-numbered oldest slot, stores
// the key with a fresh stamp and reports whether a valid entry was evicted.
// A lookup scans the filled entries of the key and stamp RAMs through their
// single read port, one entry per cycle: a hit ends the scan at the matching
// entry, a miss reads every filled entry, and a lookup into an empty store
// skips the scan. A two-entry request queue keeps accepting transactions
// during a scan, and the result sits in an output register while the next
// lookup starts. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module glyph_cache_lru_allocator_top #(
  parameter int ENTRIES     = gclru_pkg::ENTRIES_DEF,
  parameter int STAMP_WIDTH = gclru_pkg::STAMP_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  gclru_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output gclru_pkg::rsp_t rsp
);

  gclru_pkg::req_head_t head;
  logic                 pop;

  gclru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .pop       (pop)
  );

  gclru_back #(
    .ENTRIES     (ENTRIES),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/gclru_ram.sv -----
// ----------------------------------------------------------------------------
// gclru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gclru_ram #(
  parameter int WIDTH = gclru_pkg::KEY_W,
  parameter int DEPTH = gclru_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/gclru_front.sv -----
// ----------------------------------------------------------------------------
// gclru_front
// Request intake: takes lookup transactions into a short queue that feeds the
// scan engine, so the input side keeps moving while a lookup is in progress.
// ----------------------------------------------------------------------------
module gclru_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  gclru_pkg::req_t       req,
  output gclru_pkg::req_head_t  head,
  input  logic                  pop
);

  localparam int PW = (gclru_pkg::QUEUE_DEPTH > 1) ? $clog2(gclru_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(gclru_pkg::QUEUE_DEPTH + 1);

  gclru_pkg::req_t qmem [gclru_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;

  assign req_stall  = (count == CW'(gclru_pkg::QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head.valid = (count != '0);
  assign head.key   = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(gclru_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(gclru_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/gclru_back.sv -----
// ----------------------------------------------------------------------------
// gclru_back
// Scan engine: walks the filled entries of the tag and stamp RAMs one per
// cycle, looks for a key match and tracks the oldest stamp, then updates the
// chosen entry and presents the result in an output register.
// ----------------------------------------------------------------------------
module gclru_back #(
  parameter int ENTRIES     = gclru_pkg::ENTRIES_DEF,
  parameter int STAMP_WIDTH = gclru_pkg::STAMP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gclru_pkg::req_head_t head,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output gclru_pkg::rsp_t      rsp
);

  localparam int IDXW  = $clog2(ENTRIES);
  localparam int FILLW = IDXW + 1;
  localparam int SLOTX = IDXW + gclru_pkg::SLOT_W;

  gclru_pkg::state_t state, state_next;

  // entries are allocated in order and never freed, so valid = index < fill
  logic [FILLW-1:0]            fill;
  logic [STAMP_WIDTH-1:0]      counter;
  logic [STAMP_WIDTH-1:0]      fresh;
  logic [FILLW-1:0]            issue_cnt;
  logic                        chk_valid;
  logic [IDXW-1:0]             chk_idx;
  logic                        min_seen;
  logic [STAMP_WIDTH-1:0]      min_stamp;
  logic [IDXW-1:0]             min_idx;
  logic                        res_hit;
  logic [IDXW-1:0]             res_idx;

  logic                        rd_en;
  logic [IDXW-1:0]             rd_addr;
  logic [gclru_pkg::KEY_W-1:0] key_rd;
  logic [gclru_pkg::KEY_W-1:0] key_vec;
  logic [STAMP_WIDTH-1:0]      stamp_rd;
  logic                        full;
  logic                        match;
  logic                        take_min;
  logic [IDXW-1:0]             cand_idx;
  logic                        last_chk;
  logic                        rsp_free;
  logic                        start;
  logic                        commit;
  logic [SLOTX-1:0]            slot_wide;

  assign key_vec   = head.key;
  assign full      = (fill == FILLW'(ENTRIES));
  assign fresh     = counter + STAMP_WIDTH'(1);
  assign match     = chk_valid && (key_rd == key_vec);
  assign take_min  = !min_seen || (stamp_rd < min_stamp);
  assign cand_idx  = take_min ? chk_idx : min_idx;
  assign last_chk  = chk_valid && ((FILLW'(chk_idx) + FILLW'(1)) == fill);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rd_addr   = issue_cnt[IDXW-1:0];
  assign slot_wide = SLOTX'(res_idx);
  assign pop       = commit;

  gclru_ram #(
    .WIDTH (gclru_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (commit && !res_hit),
    .wr_addr (res_idx),
    .wr_data (key_vec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  gclru_ram #(
    .WIDTH (STAMP_WIDTH),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (res_idx),
    .wr_data (fresh),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gclru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    start      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      gclru_pkg::ST_IDLE: begin
        if (head.valid) begin
          start      = 1'b1;
          state_next = (fill == '0) ? gclru_pkg::ST_WRITE : gclru_pkg::ST_SCAN;
        end
      end
      gclru_pkg::ST_SCAN: begin
        rd_en = (issue_cnt < fill);
        if (match || last_chk) begin
          state_next = gclru_pkg::ST_WRITE;
        end
      end
      gclru_pkg::ST_WRITE: begin
        if (rsp_free) begin
          commit     = 1'b1;
          state_next = gclru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gclru_pkg::ST_IDLE;
      end
    endcase
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (start) begin
      chk_valid <= 1'b0;
    end else if (state == gclru_pkg::ST_SCAN) begin
      chk_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      issue_cnt <= '0;
      min_seen  <= 1'b0;
      res_hit   <= 1'b0;
      res_idx   <= '0;
    end else if (state == gclru_pkg::ST_SCAN) begin
      if (rd_en) begin
        issue_cnt <= issue_cnt + FILLW'(1);
      end
      chk_idx <= rd_addr;
      if (chk_valid && take_min) begin
        min_stamp <= stamp_rd;
        min_idx   <= chk_idx;
        min_seen  <= 1'b1;
      end
      if (match) begin
        res_hit <= 1'b1;
        res_idx <= chk_idx;
      end else if (last_chk) begin
        res_hit <= 1'b0;
        res_idx <= full ? cand_idx : fill[IDXW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      counter   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (commit) begin
        counter <= fresh;
        if (!res_hit && !full) begin
          fill <= fill + FILLW'(1);
        end
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.hit     <= res_hit;
      rsp.slot    <= slot_wide[gclru_pkg::SLOT_W-1:0];
      rsp.evicted <= !res_hit && full;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph cache tag store. Lookup transactions are
// fed from a queue: a short directed run over the key field extremes, hits
// and near-miss keys, then about a thousand random lookups. The random lookups
// first fill the store and then mix recent keys, old keys, fresh keys and
// one-bit variants so that hits, free allocations and LRU evictions all occur.
// A local copy of the tag store predicts hit, slot and evicted for every
// accepted lookup. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int          ENTRIES     = gclru_pkg::ENTRIES_DEF;
  localparam int          STAMP_W     = gclru_pkg::STAMP_WIDTH_DEF;
  localparam int          SLOT_W      = gclru_pkg::SLOT_W;
  localparam int          KEY_W       = gclru_pkg::KEY_W;
  localparam int          RANDOM_RUN  = 1000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          MAX_REPORTS = 100;

  typedef struct {
    gclru_pkg::req_t key;
    bit              drain_first;
  } lookup_item_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  gclru_pkg::req_t req = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  gclru_pkg::rsp_t rsp;

  always #5 clk = ~clk;

  glyph_cache_lru_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // local tag store
  bit                 tag_valid [ENTRIES];
  gclru_pkg::req_t    tag_key   [ENTRIES];
  logic [STAMP_W-1:0] tag_stamp [ENTRIES];
  logic [STAMP_W-1:0] access_count = '0;

  lookup_item_t    lookup_queue[$];
  gclru_pkg::rsp_t awaited_answers[$];
  int              n_req_acc = 0;
  int              n_rsp_acc = 0;
  int              errors = 0;
  int unsigned     cycle_count = 0;

  function automatic gclru_pkg::rsp_t lookup_glyph(gclru_pkg::req_t k);
    gclru_pkg::rsp_t    r;
    int                 pick;
    bit                 have_free;
    logic [STAMP_W-1:0] oldest;
    r = '0;
    pick = -1;
    have_free = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (pick < 0 && tag_valid[i] && tag_key[i] == k) pick = i;
    access_count = access_count + STAMP_W'(1);
    if (pick >= 0) begin
      tag_stamp[pick] = access_count;
      r.hit = 1'b1;
      r.slot = SLOT_W'(pick);
      return r;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!have_free && !tag_valid[i]) begin
        pick = i;
        have_free = 1'b1;
      end
    if (!have_free) begin
      // strict less-than keeps the lowest slot on equal stamps
      pick = 0;
      oldest = tag_stamp[0];
      for (int i = 1; i < ENTRIES; i++)
        if (tag_stamp[i] < oldest) begin
          oldest = tag_stamp[i];
          pick = i;
        end
    end
    tag_valid[pick] = 1'b1;
    tag_key[pick] = k;
    tag_stamp[pick] = access_count;
    r.slot = SLOT_W'(pick);
    r.evicted = !have_free;
    return r;
  endfunction

  function automatic gclru_pkg::req_t random_key();
    gclru_pkg::req_t k;
    k.glyph_index = 16'($urandom);
    k.pixel_size  = 10'($urandom);
    k.style_bits  = 8'($urandom);
    k.angle       = $urandom;
    return k;
  endfunction

  function automatic gclru_pkg::req_t flip_one_bit(gclru_pkg::req_t k);
    logic [KEY_W-1:0] bits;
    int unsigned      pos;
    bits = k;
    pos = $urandom_range(0, KEY_W - 1);
    bits[pos] = ~bits[pos];
    return gclru_pkg::req_t'(bits);
  endfunction

  function automatic int unsigned pick_gap(bit quiet, int unsigned long_max);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 999);
    if (roll < 930) return 0;
    if (roll < 990) return $urandom_range(1, 4);
    return $urandom_range(20, long_max);
  endfunction

  // request driver
  int unsigned gap_left = 0;
  bit          send_quiet = 1'b0;

  always @(posedge clk) begin
    bit           acc;
    bit           settled;
    lookup_item_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      acc = req_valid && !req_stall;
      settled = (n_req_acc + int'(acc)) == (n_rsp_acc + int'(rsp_valid && !rsp_stall));
      if (acc) begin
        awaited_answers.push_back(lookup_glyph(req));
        n_req_acc <= n_req_acc + 1;
      end
      if (!req_valid || acc) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (lookup_queue.size() != 0 &&
                     !(lookup_queue[0].drain_first && !settled)) begin
          nxt = lookup_queue.pop_front();
          req <= nxt.key;
          req_valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
          gap_left <= pick_gap(send_quiet, 300);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  int unsigned stall_left = 0;
  bit          recv_quiet = 1'b0;

  task automatic flag_mismatch(string field, int want, int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    gclru_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_rsp_acc <= n_rsp_acc + 1;
        if (awaited_answers.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected transaction expected none %s%0d slot=%0d evicted=%0d",
                     $time, "actual hit=", rsp.hit, rsp.slot, rsp.evicted);
        end else begin
          want = awaited_answers.pop_front();
          if (rsp.hit !== want.hit)
            flag_mismatch("hit", int'(want.hit), int'(rsp.hit));
          if (rsp.slot !== want.slot)
            flag_mismatch("slot", int'(want.slot), int'(rsp.slot));
          if (rsp.evicted !== want.evicted)
            flag_mismatch("evicted", int'(want.evicted), int'(rsp.evicted));
        end
      end
      if ($urandom_range(0, 1999) == 0) recv_quiet = !recv_quiet;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        stall_left <= pick_gap(recv_quiet, 300);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  gclru_pkg::req_t seen_keys[$];

  task automatic queue_lookup(gclru_pkg::req_t k, bit drain_first);
    lookup_item_t it;
    it.key = k;
    it.drain_first = drain_first;
    lookup_queue.push_back(it);
    seen_keys.push_back(k);
  endtask

  initial begin
    gclru_pkg::req_t k;
    int unsigned     roll;
    int unsigned     fresh_pct;
    int unsigned     depth;

    // field extremes
    queue_lookup('0, 1'b0);
    queue_lookup('{16'hFFFF, 10'h3FF, 8'hFF, 32'hFFFF_FFFF}, 1'b0);
    queue_lookup('{16'h0000, 10'h000, 8'h00, 32'h8000_0000}, 1'b0);
    queue_lookup('{16'h0000, 10'h000, 8'h00, 32'h7FFF_FFFF}, 1'b0);
    // hits on earlier keys
    queue_lookup('0, 1'b0);
    queue_lookup('{16'hFFFF, 10'h3FF, 8'hFF, 32'hFFFF_FFFF}, 1'b0);
    queue_lookup('{16'h0000, 10'h000, 8'h00, 32'h8000_0000}, 1'b0);
    // keys one field away from the all-zero key, then one bit off the all-ones key
    queue_lookup('{16'h8000, 10'h000, 8'h00, 32'h0000_0000}, 1'b0);
    queue_lookup('{16'h0000, 10'h200, 8'h00, 32'h0000_0000}, 1'b0);
    queue_lookup('{16'h0000, 10'h000, 8'h80, 32'h0000_0000}, 1'b0);
    queue_lookup('{16'h0000, 10'h000, 8'h00, 32'h0000_0001}, 1'b0);
    queue_lookup('{16'hFFFF, 10'h3FF, 8'hFF, 32'h7FFF_FFFF}, 1'b0);
    for (int i = 0; i < 6; i++) queue_lookup(random_key(), 1'b0);
    for (int i = 0; i < 4; i++)
      queue_lookup(seen_keys[seen_keys.size() - 1 - 2 * i], 1'b0);
    queue_lookup('0, 1'b0);

    for (int n = 0; n < RANDOM_RUN; n++) begin
      // first half mostly fills the store, second half works it under eviction
      fresh_pct = (n < RANDOM_RUN / 2) ? 80 : 35;
      roll = $urandom_range(0, 99);
      if (roll < fresh_pct) begin
        k = random_key();
      end else if (roll < fresh_pct + 7) begin
        k = flip_one_bit(seen_keys[$urandom_range(0, seen_keys.size() - 1)]);
      end else if (roll < fresh_pct + 7 + (100 - fresh_pct - 7) / 2) begin
        depth = (seen_keys.size() < 48) ? seen_keys.size() : 48;
        k = seen_keys[seen_keys.size() - 1 - $urandom_range(0, depth - 1)];
      end else begin
        k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      end
      queue_lookup(k, n == 0 || n == RANDOM_RUN / 2 || n == 3 * RANDOM_RUN / 4);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (lookup_queue.size() != 0 || req_valid) @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
